FILE: rtl/itp_pkg.sv
// ============================================================================
// itp_pkg
// Shared types, constants and helper functions for the infix to postfix
// converter: item structs, stack symbol codes, error codes and priorities.
// ============================================================================
package itp_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W       = 3;

    // Results one item may cause
    localparam int MAX_RESULTS = 16;
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

    // ASCII codes
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Stack symbol codes
    typedef enum logic [SYM_W-1:0] {
        SYM_NONE  = 3'd0,
        SYM_OPEN  = 3'd1,
        SYM_PLUS  = 3'd2,
        SYM_MINUS = 3'd3,
        SYM_MUL   = 3'd4,
        SYM_DIV   = 3'd5
    } sym_t;

    // Sticky error codes
    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_CLOSE = 3'd1,
        ERR_OPEN  = 3'd2,
        ERR_OVF   = 3'd3,
        ERR_BAD   = 3'd4
    } err_t;

    // Kind of item being worked on
    typedef enum logic [1:0] {
        MODE_CHAR  = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_OPER  = 2'd2,
        MODE_END   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
        logic       expr_done;
        logic [2:0] error_code;
    } out_item_t;

    // Controller requests to the output stage
    typedef struct packed {
        logic       emit;        // load pending, push old pending
        logic       flush;       // push pending (if any)
        logic       flush_last;  // run_last for the flushed item
        logic       close;       // push the closing item
        logic [7:0] chr;
        err_t       err;
    } out_req_t;

    // Output stage status
    typedef struct packed {
        logic pend_valid;
        logic out_free;
    } out_stat_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {[CH_D0:CH_D9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]});
    endfunction

    function automatic sym_t classify(input logic [7:0] c);
        case (c)
            CH_OPEN:  return SYM_OPEN;
            CH_PLUS:  return SYM_PLUS;
            CH_MINUS: return SYM_MINUS;
            CH_MUL:   return SYM_MUL;
            CH_DIV:   return SYM_DIV;
            default:  return SYM_NONE;
        endcase
    endfunction

    function automatic logic [7:0] sym_char(input sym_t s);
        case (s)
            SYM_OPEN:  return CH_OPEN;
            SYM_PLUS:  return CH_PLUS;
            SYM_MINUS: return CH_MINUS;
            SYM_MUL:   return CH_MUL;
            SYM_DIV:   return CH_DIV;
            default:   return CH_NUL;
        endcase
    endfunction

    function automatic logic [1:0] sym_prio(input sym_t s);
        case (s)
            SYM_PLUS, SYM_MINUS: return 2'd1;
            SYM_MUL, SYM_DIV:    return 2'd2;
            default:             return 2'd0;
        endcase
    endfunction

    // Keep only the first error of an expression
    function automatic err_t set_err(input err_t cur, input err_t code);
        return (cur == ERR_OK) ? code : cur;
    endfunction

endpackage

FILE: rtl/infix_to_postfix_converter.sv
// ============================================================================
// infix_to_postfix_converter
// Shunting-yard infix to postfix converter, one ASCII character per item,
// with the operator stack held in a synchronous RAM.
// ============================================================================
// Usage:
//   s_ channel: one item per character (char_code) or an end marker
//   (is_end = 1). m_ channel: zero or more result items per input item;
//   run_last marks the last one. After an end marker the stack is flushed
//   and a closing item (char_valid = 0, expr_done = 1) carries the sticky
//   error code of the expression, which is then cleared.
//   Steps: an operand is loaded as the pending result, then flushed; a
//   push, a stray character or an empty-stack close is done on acceptance;
//   an item that walks the stack reads one entry per step (ST_EVAL). Then
//   the pending result is flushed (ST_FIN), and after an end marker the
//   closing item is sent (ST_DONE). The walk is set by the stack RAM: one
//   read per cycle unless the output stage stalls, read data registered.
//   One result is held back until the next is known (to set run_last); an
//   output register sits behind it. When m_ready is low the walk pauses
//   once both are full, and no new item is accepted until the current one
//   has handed all its results on.
//   Reset (aresetn low, synchronous) empties the stack, clears the error
//   and drops any result not yet taken. The RAM needs no clearing.
// ============================================================================
module infix_to_postfix_converter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  itp_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output itp_pkg::out_item_t  m_item
);

    logic                        wr_en;
    logic [itp_pkg::ADDR_W-1:0]  wr_addr;
    logic [itp_pkg::SYM_W-1:0]   wr_data;
    logic                        rd_en;
    logic [itp_pkg::ADDR_W-1:0]  rd_addr;
    logic [itp_pkg::SYM_W-1:0]   rd_data;
    itp_pkg::out_req_t           req;
    itp_pkg::out_stat_t          stat;

    // Operator stack
    itp_ram #(
        .WIDTH (itp_pkg::SYM_W),
        .DEPTH (itp_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer
    itp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .req     (req),
        .stat    (stat)
    );

    // Output stage
    itp_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Checks
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !stat.pend_valid)
        else $error("pending result left over when taking a new item");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ((req.emit || req.flush) && stat.pend_valid) || req.close |-> stat.out_free)
        else $error("result pushed into a full output register");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({req.emit, req.flush, req.close}))
        else $error("conflicting output stage requests");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.expr_done |-> m_item.run_last && !m_item.char_valid)
        else $error("closing item without run_last");

endmodule

FILE: rtl/itp_ram.sv
// ============================================================================
// itp_ram
// Generic single-write, single-read synchronous RAM; read data registered
// and held while no read is issued.
// ============================================================================
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/itp_out.sv
// ============================================================================
// itp_out
// Output stage: one pending item held back until the next one is known,
// so run_last can be set, followed by the m_ output register.
// ============================================================================
module itp_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  itp_pkg::out_req_t   req,
    output itp_pkg::out_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output itp_pkg::out_item_t  m_item
);

    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_char_reg, pend_char_next;
    itp_pkg::err_t     pend_err_reg, pend_err_next;
    logic              out_valid_reg, out_valid_next;
    itp_pkg::out_item_t out_reg, out_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_ready;

    // Next-state logic
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;

        if (req.emit) begin
            if (pend_valid_reg) begin
                out_valid_next      = 1'b1;
                out_next.out_char   = pend_char_reg;
                out_next.char_valid = 1'b1;
                out_next.run_last   = 1'b0;
                out_next.expr_done  = 1'b0;
                out_next.error_code = 3'(pend_err_reg);
            end
            pend_valid_next = 1'b1;
            pend_char_next  = req.chr;
            pend_err_next   = req.err;
        end else if (req.flush) begin
            if (pend_valid_reg) begin
                out_valid_next      = 1'b1;
                out_next.out_char   = pend_char_reg;
                out_next.char_valid = 1'b1;
                out_next.run_last   = req.flush_last;
                out_next.expr_done  = 1'b0;
                out_next.error_code = 3'(pend_err_reg);
            end
            pend_valid_next = 1'b0;
        end else if (req.close) begin
            out_valid_next      = 1'b1;
            out_next.out_char   = itp_pkg::CH_NUL;
            out_next.char_valid = 1'b0;
            out_next.run_last   = 1'b1;
            out_next.expr_done  = 1'b1;
            out_next.error_code = 3'(req.err);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_char_reg <= pend_char_next;
        pend_err_reg  <= pend_err_next;
        out_reg       <= out_next;
    end

    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;
    assign m_valid         = out_valid_reg;
    assign m_item          = out_reg;

endmodule

FILE: rtl/itp_ctrl.sv
// ============================================================================
// itp_ctrl
// Shunting-yard sequencer: classifies each item, walks the operator stack in
// RAM one entry per cycle unless stalled, and drives the output stage.
// ============================================================================
module itp_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  itp_pkg::in_item_t               s_item,
    output logic                            wr_en,
    output logic [itp_pkg::ADDR_W-1:0]      wr_addr,
    output logic [itp_pkg::SYM_W-1:0]       wr_data,
    output logic                            rd_en,
    output logic [itp_pkg::ADDR_W-1:0]      rd_addr,
    input  logic [itp_pkg::SYM_W-1:0]       rd_data,
    output itp_pkg::out_req_t               req,
    input  itp_pkg::out_stat_t              stat
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [itp_pkg::CNT_W-1:0]   count_reg, count_next;
    itp_pkg::err_t               err_reg, err_next;
    itp_pkg::mode_t              mode_reg, mode_next;
    itp_pkg::sym_t               sym_reg, sym_next;
    logic [itp_pkg::EMIT_W-1:0]  nemit_reg, nemit_next;

    logic                        accept;
    logic                        eval_go;
    itp_pkg::sym_t               in_sym;
    itp_pkg::sym_t               top_sym;
    logic [itp_pkg::CNT_W-1:0]   cnt_dec;
    logic                        stack_full;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign in_sym     = itp_pkg::classify(s_item.char_code);
    assign top_sym    = itp_pkg::sym_t'(rd_data);
    assign cnt_dec    = count_reg - 1'b1;
    assign stack_full = (count_reg >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    // A new emit may push the old pending item, so the output must be free
    assign eval_go    = !stat.pend_valid || stat.out_free;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        err_next   = err_reg;
        mode_next  = mode_reg;
        sym_next   = sym_reg;
        nemit_next = nemit_reg;

        wr_en   = 1'b0;
        wr_addr = count_reg[itp_pkg::ADDR_W-1:0];
        wr_data = sym_reg;
        rd_en   = 1'b0;
        rd_addr = cnt_dec[itp_pkg::ADDR_W-1:0];

        req            = '0;
        req.chr        = itp_pkg::sym_char(top_sym);
        req.err        = err_reg;
        req.flush_last = (mode_reg != itp_pkg::MODE_END);

        case (state_reg)
            ST_IDLE: begin
                nemit_next = '0;
                sym_next   = in_sym;
                if (accept) begin
                    if (s_item.is_end) begin
                        mode_next = itp_pkg::MODE_END;
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            state_next = ST_EVAL;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end else if (itp_pkg::is_alnum(s_item.char_code)) begin
                        // Operand: goes straight to pending
                        mode_next  = itp_pkg::MODE_CHAR;
                        req.emit   = 1'b1;
                        req.chr    = s_item.char_code;
                        state_next = ST_FIN;
                    end else if (s_item.char_code == itp_pkg::CH_CLOSE) begin
                        mode_next = itp_pkg::MODE_CLOSE;
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            state_next = ST_EVAL;
                        end else begin
                            err_next = itp_pkg::set_err(err_reg, itp_pkg::ERR_CLOSE);
                        end
                    end else if (in_sym == itp_pkg::SYM_NONE) begin
                        err_next = itp_pkg::set_err(err_reg, itp_pkg::ERR_BAD);
                    end else if (in_sym == itp_pkg::SYM_OPEN) begin
                        if (stack_full) begin
                            err_next = itp_pkg::set_err(err_reg, itp_pkg::ERR_OVF);
                        end else begin
                            wr_en      = 1'b1;
                            wr_data    = in_sym;
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        mode_next = itp_pkg::MODE_OPER;
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            state_next = ST_EVAL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_data    = in_sym;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end

            ST_EVAL: begin
                if (eval_go) begin
                    case (mode_reg)
                        itp_pkg::MODE_END: begin
                            count_next = cnt_dec;
                            if (top_sym == itp_pkg::SYM_OPEN) begin
                                err_next = itp_pkg::set_err(err_reg, itp_pkg::ERR_OPEN);
                            end else if (nemit_reg <
                                         itp_pkg::EMIT_W'(itp_pkg::MAX_RESULTS - 1)) begin
                                req.emit   = 1'b1;
                                nemit_next = nemit_reg + 1'b1;
                            end else begin
                                err_next = itp_pkg::set_err(err_reg, itp_pkg::ERR_OVF);
                            end
                            if (cnt_dec != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = itp_pkg::ADDR_W'(cnt_dec - 1'b1);
                            end else begin
                                state_next = ST_FIN;
                            end
                        end

                        itp_pkg::MODE_CLOSE: begin
                            count_next = cnt_dec;
                            if (top_sym == itp_pkg::SYM_OPEN) begin
                                state_next = ST_FIN;
                            end else begin
                                if (nemit_reg < itp_pkg::EMIT_W'(itp_pkg::MAX_RESULTS)) begin
                                    req.emit   = 1'b1;
                                    nemit_next = nemit_reg + 1'b1;
                                end
                                if (cnt_dec != '0) begin
                                    rd_en   = 1'b1;
                                    rd_addr = itp_pkg::ADDR_W'(cnt_dec - 1'b1);
                                end else begin
                                    // Stack ran dry with no open paren
                                    err_next   = itp_pkg::set_err(err_reg,
                                                                  itp_pkg::ERR_CLOSE);
                                    state_next = ST_FIN;
                                end
                            end
                        end

                        itp_pkg::MODE_OPER: begin
                            if (itp_pkg::sym_prio(top_sym) >= itp_pkg::sym_prio(sym_reg)) begin
                                // Pop the top, keep walking or push into its slot
                                if (nemit_reg < itp_pkg::EMIT_W'(itp_pkg::MAX_RESULTS)) begin
                                    req.emit   = 1'b1;
                                    nemit_next = nemit_reg + 1'b1;
                                end
                                if (cnt_dec != '0) begin
                                    count_next = cnt_dec;
                                    rd_en      = 1'b1;
                                    rd_addr    = itp_pkg::ADDR_W'(cnt_dec - 1'b1);
                                end else begin
                                    wr_en      = 1'b1;
                                    wr_addr    = cnt_dec[itp_pkg::ADDR_W-1:0];
                                    state_next = ST_FIN;
                                end
                            end else begin
                                // Top binds looser: push above it
                                if (stack_full) begin
                                    err_next = itp_pkg::set_err(err_reg, itp_pkg::ERR_OVF);
                                end else begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                state_next = ST_FIN;
                            end
                        end

                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_FIN: begin
                // Release the pending item with its run_last flag
                if (!stat.pend_valid || stat.out_free) begin
                    req.flush  = 1'b1;
                    state_next = (mode_reg == itp_pkg::MODE_END) ? ST_DONE : ST_IDLE;
                end
            end

            ST_DONE: begin
                if (stat.out_free) begin
                    req.close  = 1'b1;
                    count_next = '0;
                    err_next   = itp_pkg::ERR_OK;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            err_reg   <= itp_pkg::ERR_OK;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // Per-item working registers
    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        sym_reg   <= sym_next;
        nemit_reg <= nemit_next;
    end

endmodule
